[design/assert_macros.svh]
// Assertion macros shared by the link extractor modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define LAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle that forces a consequence in the next cycle.
`define LAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[design/lae_pkg.sv]
// ----------------------------------------------------------------------------
// lae_pkg
// Types, constants and tag tables shared by the link extractor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lae_pkg;

  localparam int BYTE_W     = 8;
  localparam int WIN_W      = 56;
  localparam int LINKS_W    = 16;
  localparam int COUNT_BITS = 16;
  localparam int TALLY_EXT_W = (COUNT_BITS > LINKS_W) ? COUNT_BITS : LINKS_W;

  localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;
  localparam logic [LINKS_W-1:0]    LINKS_MAX = '1;

  // Queue between the scanner and the output stage.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Scanner modes.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NAME  = 2'd1;
  localparam logic [1:0] MODE_TAG   = 2'd2;
  localparam logic [1:0] MODE_VALUE = 2'd3;

  // Attribute codes.
  localparam logic [1:0] ATTR_HREF   = 2'd0;
  localparam logic [1:0] ATTR_SRC    = 2'd1;
  localparam logic [1:0] ATTR_ACTION = 2'd2;
  localparam logic [1:0] ATTR_NONE   = 2'd3;

  // Characters of interest.
  localparam logic [BYTE_W-1:0] CH_LT      = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GT      = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_DQUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQUOTE  = 8'h27;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

  // Tag openings, packed with the last byte lowest.
  localparam int NUM_TAGS = 6;
  localparam logic [WIN_W-1:0] TAG_TEXT [NUM_TAGS] = '{
    56'h3C61,            // <a
    56'h3C696D67,        // <img
    56'h3C696672616D65,  // <iframe
    56'h3C6C696E6B,      // <link
    56'h3C62617365,      // <base
    56'h3C666F726D       // <form
  };
  localparam logic [3:0] TAG_LEN [NUM_TAGS] = '{4'd2, 4'd4, 4'd7, 4'd5, 4'd5, 4'd5};
  localparam logic [1:0] TAG_ATTR [NUM_TAGS] = '{
    ATTR_HREF, ATTR_SRC, ATTR_SRC, ATTR_HREF, ATTR_HREF, ATTR_ACTION
  };

  // Attribute names; the last row is the unused code and never matches.
  localparam logic [WIN_W-1:0] ATTR_TEXT [4] = '{
    56'h687265663D,      // href=
    56'h7372633D,        // src=
    56'h616374696F6E3D,  // action=
    56'h0
  };
  localparam logic [3:0] ATTR_LEN [4] = '{4'd5, 4'd4, 4'd7, 4'd0};

  // One queue entry: a result byte and/or a page end marker.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_link;
    logic              has_out;
    logic              page_end;
  } entry_t;

  function automatic logic [WIN_W-1:0] byte_mask(input logic [3:0] len);
    logic [WIN_W-1:0] m;
    m = '0;
    for (int i = 0; i < WIN_W / BYTE_W; i++) begin
      if (4'(i) < len) begin
        m[BYTE_W*i +: BYTE_W] = '1;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[design/lae_in_if.sv]
// ----------------------------------------------------------------------------
// lae_in_if
// Request channel carrying page bytes into the link extractor.
// ----------------------------------------------------------------------------
`default_nettype none

interface lae_in_if;
  logic                      valid;
  logic                      ready;
  logic [lae_pkg::BYTE_W-1:0] in_byte;
  logic                      stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

`default_nettype wire

[design/lae_out_if.sv]
// ----------------------------------------------------------------------------
// lae_out_if
// Request channel carrying extracted link bytes out of the link extractor.
// ----------------------------------------------------------------------------
`default_nettype none

interface lae_out_if;
  logic                        valid;
  logic                        ready;
  logic [lae_pkg::BYTE_W-1:0]  out_byte;
  logic                        end_of_link;
  logic [lae_pkg::LINKS_W-1:0] links_found;

  modport source (output valid, output out_byte, output end_of_link,
                  output links_found, input ready);
  modport sink   (input valid, input out_byte, input end_of_link,
                  input links_found, output ready);
endinterface

`default_nettype wire

[design/lae_fifo.sv]
// ----------------------------------------------------------------------------
// lae_fifo
// Short queue that decouples the byte scanner from the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lae_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire lae_pkg::entry_t entry_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 empty_o,
  output lae_pkg::entry_t      entry_o
);

  lae_pkg::entry_t                 mem_q [lae_pkg::FIFO_DEPTH];
  logic [lae_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [lae_pkg::FIFO_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [lae_pkg::FIFO_CNT_W-1:0]  count_q, count_d;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == lae_pkg::FIFO_CNT_W'(lae_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == lae_pkg::FIFO_PTR_W'(lae_pkg::FIFO_DEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == lae_pkg::FIFO_PTR_W'(lae_pkg::FIFO_DEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `LAE_ASSERT(a_fifo_count_bound, count_q <= lae_pkg::FIFO_CNT_W'(lae_pkg::FIFO_DEPTH), "queue count above depth")
  `LAE_ASSERT(a_fifo_no_overflow, !(push_i && full_o), "push into a full queue")

endmodule

`default_nettype wire

[design/lae_front.sv]
// ----------------------------------------------------------------------------
// lae_front
// Byte scanner: lowercases each byte, tracks tag names and attributes and
// queues the link bytes and separators it finds.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lae_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  lae_in_if.sink           in_i,
  input  wire              full_i,
  output logic             push_o,
  output lae_pkg::entry_t  entry_o
);

  logic [1:0]                  mode_q, mode_d;
  logic [lae_pkg::WIN_W-1:0]   name_win_q, name_win_d;
  logic [2:0]                  name_len_q, name_len_d;
  logic [1:0]                  want_q, want_d;
  logic [lae_pkg::WIN_W-1:0]   attr_win_q, attr_win_d;
  logic                        quote_exp_q, quote_exp_d;
  logic                        quote_single_q, quote_single_d;

  logic                        accept;
  logic [lae_pkg::BYTE_W-1:0]  c;
  logic [lae_pkg::WIN_W-1:0]   name_next;
  logic [3:0]                  name_n;
  logic [lae_pkg::NUM_TAGS-1:0] tag_hit, tag_alive;
  logic [1:0]                  hit_attr;
  logic [lae_pkg::WIN_W-1:0]   attr_next;
  logic                        attr_match;
  logic [lae_pkg::BYTE_W-1:0]  close_quote;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    c = in_i.in_byte;
    if (in_i.in_byte inside {[lae_pkg::CH_UPPER_A:lae_pkg::CH_UPPER_Z]}) begin
      c = in_i.in_byte + lae_pkg::CASE_DELTA;
    end
  end

  // Tag name compare against every known opening at once.
  assign name_next = {name_win_q[lae_pkg::WIN_W-lae_pkg::BYTE_W-1:0], c};
  assign name_n    = {1'b0, name_len_q} + 4'd1;

  always_comb begin
    hit_attr = lae_pkg::ATTR_HREF;
    for (int i = 0; i < lae_pkg::NUM_TAGS; i++) begin
      tag_hit[i]   = (name_n == lae_pkg::TAG_LEN[i]) && (name_next == lae_pkg::TAG_TEXT[i]);
      tag_alive[i] = (name_n < lae_pkg::TAG_LEN[i]) &&
                     ((lae_pkg::TAG_TEXT[i] >> {lae_pkg::TAG_LEN[i] - name_n, 3'b000})
                      == name_next);
      if (tag_hit[i]) begin
        hit_attr = lae_pkg::TAG_ATTR[i];
      end
    end
  end

  assign attr_next  = {attr_win_q[lae_pkg::WIN_W-lae_pkg::BYTE_W-1:0], c};
  assign attr_match = (want_q != lae_pkg::ATTR_NONE) &&
                      ((attr_next & lae_pkg::byte_mask(lae_pkg::ATTR_LEN[want_q]))
                       == lae_pkg::ATTR_TEXT[want_q]);
  assign close_quote = quote_single_q ? lae_pkg::CH_SQUOTE : lae_pkg::CH_DQUOTE;

  always_comb begin
    mode_d         = mode_q;
    name_win_d     = name_win_q;
    name_len_d     = name_len_q;
    want_d         = want_q;
    attr_win_d     = attr_win_q;
    quote_exp_d    = quote_exp_q;
    quote_single_d = quote_single_q;
    entry_o        = '0;
    entry_o.out_byte = c;

    if (accept) begin
      case (mode_q)
        lae_pkg::MODE_IDLE: begin
          if (c == lae_pkg::CH_LT) begin
            mode_d     = lae_pkg::MODE_NAME;
            name_win_d = lae_pkg::WIN_W'(lae_pkg::CH_LT);
            name_len_d = 3'd1;
          end
        end
        lae_pkg::MODE_NAME: begin
          if (|tag_hit) begin
            mode_d      = lae_pkg::MODE_TAG;
            want_d      = hit_attr;
            attr_win_d  = '0;
            quote_exp_d = 1'b0;
            name_win_d  = '0;
            name_len_d  = '0;
          end else if (|tag_alive) begin
            name_win_d = name_next;
            name_len_d = name_n[2:0];
          end else if (c == lae_pkg::CH_LT) begin
            // The byte that broke the match may open a new tag itself.
            name_win_d = lae_pkg::WIN_W'(lae_pkg::CH_LT);
            name_len_d = 3'd1;
          end else begin
            mode_d         = lae_pkg::MODE_IDLE;
            name_win_d     = '0;
            name_len_d     = '0;
            want_d         = lae_pkg::ATTR_HREF;
            attr_win_d     = '0;
            quote_exp_d    = 1'b0;
            quote_single_d = 1'b0;
          end
        end
        lae_pkg::MODE_TAG: begin
          if (c == lae_pkg::CH_GT) begin
            mode_d         = lae_pkg::MODE_IDLE;
            name_win_d     = '0;
            name_len_d     = '0;
            want_d         = lae_pkg::ATTR_HREF;
            attr_win_d     = '0;
            quote_exp_d    = 1'b0;
            quote_single_d = 1'b0;
          end else if (quote_exp_q && (c == lae_pkg::CH_DQUOTE || c == lae_pkg::CH_SQUOTE)) begin
            quote_exp_d    = 1'b0;
            quote_single_d = (c == lae_pkg::CH_SQUOTE);
            mode_d         = lae_pkg::MODE_VALUE;
          end else begin
            attr_win_d  = attr_next;
            quote_exp_d = attr_match;
          end
        end
        lae_pkg::MODE_VALUE: begin
          entry_o.has_out = 1'b1;
          if (c == close_quote) begin
            entry_o.out_byte    = lae_pkg::CH_NEWLINE;
            entry_o.end_of_link = 1'b1;
            mode_d              = lae_pkg::MODE_TAG;
            attr_win_d          = '0;
            quote_exp_d         = 1'b0;
          end
        end
        default: begin
          mode_d = lae_pkg::MODE_IDLE;
        end
      endcase

      // The last byte of a page returns the scanner to its reset state.
      if (in_i.stream_end) begin
        entry_o.page_end = 1'b1;
        mode_d           = lae_pkg::MODE_IDLE;
        name_win_d       = '0;
        name_len_d       = '0;
        want_d           = lae_pkg::ATTR_HREF;
        attr_win_d       = '0;
        quote_exp_d      = 1'b0;
        quote_single_d   = 1'b0;
      end
    end
  end

  assign push_o = accept && (entry_o.has_out || entry_o.page_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= lae_pkg::MODE_IDLE;
      name_win_q     <= '0;
      name_len_q     <= '0;
      want_q         <= lae_pkg::ATTR_HREF;
      attr_win_q     <= '0;
      quote_exp_q    <= 1'b0;
      quote_single_q <= 1'b0;
    end else begin
      mode_q         <= mode_d;
      name_win_q     <= name_win_d;
      name_len_q     <= name_len_d;
      want_q         <= want_d;
      attr_win_q     <= attr_win_d;
      quote_exp_q    <= quote_exp_d;
      quote_single_q <= quote_single_d;
    end
  end

  `LAE_ASSERT(a_front_quote_in_tag, !quote_exp_q || mode_q == lae_pkg::MODE_TAG, "quote expected outside a tag")
  `LAE_ASSERT(a_front_name_len, mode_q != lae_pkg::MODE_NAME || name_len_q != 3'd0, "empty tag name while reading a name")

endmodule

`default_nettype wire

[design/lae_back.sv]
// ----------------------------------------------------------------------------
// lae_back
// Output stage: keeps the link tally and registers each result request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lae_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  empty_i,
  input  wire lae_pkg::entry_t entry_i,
  output logic                 pop_o,
  lae_out_if.source            out_o
);

  logic [lae_pkg::COUNT_BITS-1:0]  tally_q, tally_d;
  logic [lae_pkg::COUNT_BITS-1:0]  tally_now;
  logic [lae_pkg::TALLY_EXT_W-1:0] tally_ext;
  logic                            valid_q, valid_d;
  logic [lae_pkg::BYTE_W-1:0]      byte_q;
  logic                            eol_q;
  logic [lae_pkg::LINKS_W-1:0]     links_q;
  logic                            load;

  assign pop_o = !empty_i && (!valid_q || out_o.ready);
  assign load  = pop_o && entry_i.has_out;

  // Tally including the link closed by this entry, if any.
  always_comb begin
    tally_now = tally_q;
    if (pop_o && entry_i.end_of_link && tally_q != lae_pkg::TALLY_MAX) begin
      tally_now = tally_q + 1'b1;
    end
  end

  assign tally_ext = lae_pkg::TALLY_EXT_W'(tally_now);

  always_comb begin
    tally_d = tally_now;
    if (pop_o && entry_i.page_end) begin
      tally_d = '0;
    end
    valid_d = valid_q && !out_o.ready;
    if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
      valid_q <= 1'b0;
    end else begin
      tally_q <= tally_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= entry_i.out_byte;
      eol_q   <= entry_i.end_of_link;
      links_q <= (tally_ext > lae_pkg::TALLY_EXT_W'(lae_pkg::LINKS_MAX)) ? lae_pkg::LINKS_MAX
                 : tally_ext[lae_pkg::LINKS_W-1:0];
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.end_of_link = eol_q;
  assign out_o.links_found = links_q;

  `LAE_ASSERT_NEXT(a_back_tally_sat, tally_q == lae_pkg::TALLY_MAX && !(pop_o && entry_i.page_end), tally_q == lae_pkg::TALLY_MAX, "link tally wrapped")

endmodule

`default_nettype wire

[design/html_link_attribute_extractor_unit.sv]
// ----------------------------------------------------------------------------
// html_link_attribute_extractor_unit
// Byte-serial scanner that pulls href, src and action values out of HTML.
// ----------------------------------------------------------------------------
// The block takes one page byte per clock cycle on in_i and sends each link
// byte, followed by a newline separator, on out_o. The scanner keeps its
// whole state in one set of registers that update once per accepted byte,
// which sets the rate of one byte per cycle. Results pass a four-entry queue
// and then an output register before they show on out_o; in_i stays ready as
// long as the queue has room, and a stalled out_o only holds in_i off once
// the queue fills. links_found counts the links closed so far in the current
// page and stops at its maximum; stream_end on the last byte of a page clears
// the scan and the count.
`default_nettype none

module html_link_attribute_extractor_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  lae_in_if.sink     in_i,
  lae_out_if.source  out_o
);

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  lae_pkg::entry_t push_entry;
  lae_pkg::entry_t pop_entry;

  lae_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  lae_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (pop_entry)
  );

  lae_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
